### rtl/lobm_pkg.sv
package lobm_pkg;

  // Default book geometry
  localparam int unsigned PRICE_LEVELS_DEF = 512;
  localparam int unsigned LEVEL_DEPTH_DEF  = 8;

  // Window base after reset
  localparam logic [31:0] BASE_RESET = 32'd24800;

  // Order side and kind codes
  localparam logic [1:0] SIDE_BUY     = 2'd1;
  localparam logic [1:0] SIDE_SELL    = 2'd2;
  localparam logic [1:0] KIND_LIMIT   = 2'd1;
  localparam logic [1:0] KIND_MARKET  = 2'd2;

  // Result codes
  typedef enum logic [2:0] {
    OUT_RESTED    = 3'd0,
    OUT_TRADED    = 3'd1,
    OUT_CANCELLED = 3'd2,
    OUT_INVALID   = 3'd3,
    OUT_WINDOW    = 3'd4,
    OUT_FULL      = 3'd5
  } outcome_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_POP,
    S_POP_WAIT,
    S_PUSH_RD,
    S_PUSH_CHK,
    S_FINISH
  } state_t;

endpackage

### rtl/lobm_book.sv
module lobm_book
  import lobm_pkg::*;
#(
  parameter int unsigned PRICE_LEVELS = PRICE_LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH  = LEVEL_DEPTH_DEF,
  localparam int unsigned LW  = $clog2(PRICE_LEVELS),
  localparam int unsigned HW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1,
  localparam int unsigned CW  = $clog2(LEVEL_DEPTH + 1),
  localparam int unsigned AW  = $clog2(PRICE_LEVELS * LEVEL_DEPTH)
) (
  input  logic             clk,
  input  logic             lvl_we,
  input  logic [LW-1:0]    lvl_waddr,
  input  logic [HW+CW-1:0] lvl_wdata,
  input  logic [LW-1:0]    lvl_raddr,
  output logic [HW+CW-1:0] lvl_rdata,
  input  logic             id_we,
  input  logic [AW-1:0]    id_waddr,
  input  logic [63:0]      id_wdata,
  input  logic [AW-1:0]    id_raddr,
  output logic [63:0]      id_rdata
);

  // Per-level {head, count}
  logic [HW+CW-1:0] lvl_mem [PRICE_LEVELS];
  // Resting order ids, one FIFO ring per level
  logic [63:0]      id_mem  [PRICE_LEVELS * LEVEL_DEPTH];

  // Level state memory
  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    lvl_rdata <= lvl_mem[lvl_raddr];
  end

  // Id memory
  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_waddr] <= id_wdata;
    end
    id_rdata <= id_mem[id_raddr];
  end

endmodule

### rtl/lobm_seq.sv
module lobm_seq
  import lobm_pkg::*;
#(
  parameter int unsigned PRICE_LEVELS = PRICE_LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH  = LEVEL_DEPTH_DEF,
  localparam int unsigned LW  = $clog2(PRICE_LEVELS),
  localparam int unsigned HW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1,
  localparam int unsigned CW  = $clog2(LEVEL_DEPTH + 1),
  localparam int unsigned SW  = CW + 1,
  localparam int unsigned AW  = $clog2(PRICE_LEVELS * LEVEL_DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [31:0]      cfg_write_data,
  input  logic             order_valid,
  output logic             order_stall,
  input  logic [63:0]      order_id,
  input  logic [63:0]      arrival_time,
  input  logic [1:0]       order_side,
  input  logic [1:0]       order_kind,
  input  logic [31:0]      limit_price,
  input  logic [63:0]      order_quantity,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [2:0]       outcome,
  output logic [63:0]      matched_resting_id,
  output logic [31:0]      trade_price,
  output logic [63:0]      orders_seen,
  output logic [63:0]      trades_done,
  // book memory ports, shared addressing, per-side enables
  output logic             bid_lvl_we,
  output logic             ask_lvl_we,
  output logic [LW-1:0]    lvl_waddr,
  output logic [HW+CW-1:0] lvl_wdata,
  output logic [LW-1:0]    lvl_raddr,
  input  logic [HW+CW-1:0] bid_lvl_rdata,
  input  logic [HW+CW-1:0] ask_lvl_rdata,
  output logic             bid_id_we,
  output logic             ask_id_we,
  output logic [AW-1:0]    id_waddr,
  output logic [63:0]      id_wdata,
  output logic [AW-1:0]    id_raddr,
  input  logic [63:0]      bid_id_rdata,
  input  logic [63:0]      ask_id_rdata
);

  localparam logic [LW-1:0] LAST_LVL = LW'(PRICE_LEVELS - 1);

  state_t state, state_next;

  logic [31:0]   base;
  logic [63:0]   ord_id, ord_time, ord_qty;
  logic [1:0]    ord_side, ord_kind;
  logic [31:0]   ord_price;
  logic [LW-1:0] scan_idx;
  logic [LW-1:0] lvl_idx;
  logic          best_found;
  logic [HW-1:0] best_head;
  logic [CW-1:0] best_count;
  outcome_t      pend_outcome;
  logic [63:0]   pend_matched;
  logic [31:0]   pend_price;
  logic [63:0]   order_cnt, trade_cnt;

  // Decoded order and working values
  logic          is_buy, is_market, invalid, outside;
  logic [32:0]   price_diff, best_price33;
  logic          crosses, out_free;
  logic [HW+CW-1:0] opp_lvl, own_lvl;
  logic [HW-1:0] own_head, head_inc;
  logic [CW-1:0] opp_count, own_count;
  logic [SW-1:0] slot_sum, slot_wrap;
  logic          scan_end;

  assign is_buy    = (ord_side == SIDE_BUY);
  assign is_market = (ord_kind == KIND_MARKET);
  assign invalid   = (ord_id == '0) || (ord_time == '0) || (ord_qty == '0) ||
                     (ord_price == '0) ||
                     ((ord_side != SIDE_BUY) && (ord_side != SIDE_SELL)) ||
                     ((ord_kind != KIND_LIMIT) && (ord_kind != KIND_MARKET));
  assign price_diff = {1'b0, ord_price} - {1'b0, base};
  assign outside    = price_diff[32] || (price_diff[31:0] >= 32'(PRICE_LEVELS));

  assign opp_lvl   = is_buy ? ask_lvl_rdata : bid_lvl_rdata;
  assign own_lvl   = is_buy ? bid_lvl_rdata : ask_lvl_rdata;
  assign opp_count = opp_lvl[CW-1:0];
  assign own_count = own_lvl[CW-1:0];
  assign own_head  = own_lvl[HW+CW-1:CW];
  assign scan_end  = is_buy ? (scan_idx == LAST_LVL) : (scan_idx == '0);

  // Best level price, kept at 33 bits so a level price beyond 32 bits compares without wrapping
  assign best_price33 = {1'b0, base} + 33'(scan_idx);
  assign crosses = best_found &&
                   (is_market || (is_buy ? ({1'b0, ord_price} >= best_price33)
                                         : ({1'b0, ord_price} <= best_price33)));

  assign head_inc  = (best_head == HW'(LEVEL_DEPTH - 1)) ? '0 : best_head + 1'b1;
  assign slot_sum  = SW'(own_head) + SW'(own_count);
  assign slot_wrap = (slot_sum >= SW'(LEVEL_DEPTH)) ? slot_sum - SW'(LEVEL_DEPTH) : slot_sum;

  assign out_free    = !result_valid || !result_stall;
  assign order_stall = (state != S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (scan_idx == LAST_LVL) state_next = S_IDLE;
      S_IDLE:     if (order_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (invalid || (!is_market && outside)) state_next = S_FINISH;
        else state_next = S_SCAN_RD;
      end
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: if ((opp_count != '0) || scan_end) state_next = S_DECIDE;
                  else state_next = S_SCAN_RD;
      S_DECIDE: begin
        if (crosses) state_next = S_POP;
        else if (is_market) state_next = S_FINISH;
        else state_next = S_PUSH_RD;
      end
      S_POP:      state_next = S_POP_WAIT;
      S_POP_WAIT: state_next = S_FINISH;
      S_PUSH_RD:  state_next = S_PUSH_CHK;
      S_PUSH_CHK: state_next = S_FINISH;
      S_FINISH:   if (out_free) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Memory controls
  always_comb begin
    bid_lvl_we = 1'b0;
    ask_lvl_we = 1'b0;
    lvl_waddr  = scan_idx;
    lvl_wdata  = '0;
    lvl_raddr  = scan_idx;
    bid_id_we  = 1'b0;
    ask_id_we  = 1'b0;
    id_waddr   = AW'(lvl_idx) * AW'(LEVEL_DEPTH) + AW'(slot_wrap[HW-1:0]);
    id_wdata   = ord_id;
    id_raddr   = AW'(scan_idx) * AW'(LEVEL_DEPTH) + AW'(best_head);
    unique case (state)
      S_CLEAR: begin
        bid_lvl_we = 1'b1;
        ask_lvl_we = 1'b1;
      end
      S_POP: begin
        lvl_wdata  = {head_inc, best_count - 1'b1};
        bid_lvl_we = !is_buy;
        ask_lvl_we = is_buy;
      end
      S_PUSH_RD: lvl_raddr = lvl_idx;
      S_PUSH_CHK: begin
        lvl_waddr = lvl_idx;
        lvl_wdata = {own_head, own_count + 1'b1};
        if (own_count < CW'(LEVEL_DEPTH)) begin
          bid_lvl_we = is_buy;
          ask_lvl_we = !is_buy;
          bid_id_we  = is_buy;
          ask_id_we  = !is_buy;
        end
      end
      default: ;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan_idx     <= '0;
      base         <= BASE_RESET;
      order_cnt    <= '0;
      trade_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) base <= cfg_write_data;
      if (result_valid && !result_stall && !((state == S_FINISH) && out_free))
        result_valid <= 1'b0;
      unique case (state)
        S_CLEAR:    scan_idx <= scan_idx + 1'b1;
        S_IDLE:     if (order_valid) order_cnt <= order_cnt + 1'b1;
        S_CHECK:    scan_idx <= is_buy ? '0 : LAST_LVL;
        S_SCAN_CHK: if ((opp_count == '0) && !scan_end) begin
          scan_idx <= is_buy ? scan_idx + 1'b1 : scan_idx - 1'b1;
        end
        S_POP:      trade_cnt <= trade_cnt + 1'b1;
        S_FINISH:   if (out_free) result_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ord_id    <= order_id;
        ord_time  <= arrival_time;
        ord_side  <= order_side;
        ord_kind  <= order_kind;
        ord_price <= limit_price;
        ord_qty   <= order_quantity;
      end
      S_CHECK: begin
        pend_matched <= '0;
        pend_price   <= '0;
        lvl_idx      <= price_diff[LW-1:0];
        if (invalid) pend_outcome <= OUT_INVALID;
        else pend_outcome <= OUT_WINDOW;
      end
      S_SCAN_CHK: begin
        best_found <= (opp_count != '0);
        best_head  <= opp_lvl[HW+CW-1:CW];
        best_count <= opp_count;
      end
      S_DECIDE:   pend_outcome <= OUT_CANCELLED;
      S_POP:      pend_price <= best_price33[31:0];
      S_POP_WAIT: begin
        pend_matched <= is_buy ? ask_id_rdata : bid_id_rdata;
        pend_outcome <= OUT_TRADED;
      end
      S_PUSH_CHK: pend_outcome <= (own_count < CW'(LEVEL_DEPTH)) ? OUT_RESTED : OUT_FULL;
      S_FINISH: if (out_free) begin
        outcome            <= pend_outcome;
        matched_resting_id <= pend_matched;
        trade_price        <= pend_price;
        orders_seen        <= order_cnt;
        trades_done        <= trade_cnt;
      end
      default: ;
    endcase
  end

  // No order taken during the clearing pass
  a_clear_stalls: assert property (@(posedge clk) (state == S_CLEAR) |-> order_stall)
    else $error("order accepted during clearing pass");

  // An accepted order always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (order_valid && !order_stall) |=> (state == S_CHECK))
    else $error("accepted order not started");

  // Trade count moves only when a pop is issued
  a_trade_pop: assert property (@(posedge clk) disable iff (rst)
    (trade_cnt != $past(trade_cnt)) |-> ($past(state) == S_POP))
    else $error("trade counted without pop");

  // Only a trade reports a matched id
  a_match_only_trade: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (outcome != OUT_TRADED)) |-> (matched_resting_id == '0))
    else $error("matched id without trade");

endmodule

### rtl/limit_order_book_matcher_top.sv
// Price-time priority limit order book. One order is taken at a time
// (order_stall is high while it is processed) and yields one result. An
// invalid order, or a limit order outside the window, goes straight to the
// finish state; any other order scans the opposite book's level memory from
// the best end until it finds a non-empty level or reaches the far end. A
// market order with no liquidity is then cancelled; a crossing order pops
// the best resting order as a trade; any other limit order rests on its
// level or finds it full. A previous result still stalled at the output
// holds the order in its finish state. The finished result sits in an
// output register, so the next order is accepted while it waits. After
// reset a clearing pass zeroes both books' level state; no order is taken
// meanwhile. Change the window base only while no order is in flight.
module limit_order_book_matcher_top
  import lobm_pkg::*;
#(
  parameter int unsigned PRICE_LEVELS = PRICE_LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH  = LEVEL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        order_valid,
  output logic        order_stall,
  input  logic [63:0] order_id,
  input  logic [63:0] arrival_time,
  input  logic [1:0]  order_side,
  input  logic [1:0]  order_kind,
  input  logic [31:0] limit_price,
  input  logic [63:0] order_quantity,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  outcome,
  output logic [63:0] matched_resting_id,
  output logic [31:0] trade_price,
  output logic [63:0] orders_seen,
  output logic [63:0] trades_done
);

  localparam int unsigned LW = $clog2(PRICE_LEVELS);
  localparam int unsigned HW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned AW = $clog2(PRICE_LEVELS * LEVEL_DEPTH);

  logic             bid_lvl_we, ask_lvl_we, bid_id_we, ask_id_we;
  logic [LW-1:0]    lvl_waddr, lvl_raddr;
  logic [HW+CW-1:0] lvl_wdata, bid_lvl_rdata, ask_lvl_rdata;
  logic [AW-1:0]    id_waddr, id_raddr;
  logic [63:0]      id_wdata, bid_id_rdata, ask_id_rdata;

  // Sequencer and datapath
  lobm_seq #(.PRICE_LEVELS(PRICE_LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_seq (
    .clk, .rst, .cfg_write_en, .cfg_write_data,
    .order_valid, .order_stall, .order_id, .arrival_time, .order_side,
    .order_kind, .limit_price, .order_quantity,
    .result_valid, .result_stall, .outcome, .matched_resting_id,
    .trade_price, .orders_seen, .trades_done,
    .bid_lvl_we, .ask_lvl_we, .lvl_waddr, .lvl_wdata, .lvl_raddr,
    .bid_lvl_rdata, .ask_lvl_rdata,
    .bid_id_we, .ask_id_we, .id_waddr, .id_wdata, .id_raddr,
    .bid_id_rdata, .ask_id_rdata
  );

  // Bid book
  lobm_book #(.PRICE_LEVELS(PRICE_LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_bid (
    .clk, .lvl_we(bid_lvl_we), .lvl_waddr, .lvl_wdata, .lvl_raddr,
    .lvl_rdata(bid_lvl_rdata), .id_we(bid_id_we), .id_waddr, .id_wdata,
    .id_raddr, .id_rdata(bid_id_rdata)
  );

  // Ask book
  lobm_book #(.PRICE_LEVELS(PRICE_LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_ask (
    .clk, .lvl_we(ask_lvl_we), .lvl_waddr, .lvl_wdata, .lvl_raddr,
    .lvl_rdata(ask_lvl_rdata), .id_we(ask_id_we), .id_waddr, .id_wdata,
    .id_raddr, .id_rdata(ask_id_rdata)
  );

endmodule

### verif/book_checker.sv
`timescale 1ns / 100ps

module book_checker
  import lobm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        order_valid,
  input  logic        order_stall,
  input  logic [63:0] order_id,
  input  logic [63:0] arrival_time,
  input  logic [1:0]  order_side,
  input  logic [1:0]  order_kind,
  input  logic [31:0] limit_price,
  input  logic [63:0] order_quantity,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [2:0]  outcome,
  input  logic [63:0] matched_resting_id,
  input  logic [31:0] trade_price,
  input  logic [63:0] orders_seen,
  input  logic [63:0] trades_done,
  output int          fail_count,
  output int          pending
);

  localparam int LEVELS = PRICE_LEVELS_DEF;
  localparam int DEPTH  = LEVEL_DEPTH_DEF;

  typedef struct packed {
    outcome_t    code;
    logic [63:0] matched;
    logic [31:0] price;
    logic [63:0] seen;
    logic [63:0] trades;
  } fill_t;

  fill_t fills_due[$];

  // shadow book
  logic [63:0] bid_ids [LEVELS*DEPTH];
  logic [63:0] ask_ids [LEVELS*DEPTH];
  int          bid_head [LEVELS];
  int          bid_cnt  [LEVELS];
  int          ask_head [LEVELS];
  int          ask_cnt  [LEVELS];
  logic [63:0] seen_ctr, trade_ctr;
  logic [31:0] base_price;

  assign pending = fills_due.size();

  function automatic fill_t match_order(logic [63:0] id, logic [63:0] ts, logic [1:0] side,
                                        logic [1:0] kind, logic [31:0] px, logic [63:0] qty);
    fill_t f;
    logic  buy, mkt, hit;
    int    best, lvl, slot;
    logic [32:0] off;
    buy = (side == SIDE_BUY);
    mkt = (kind == KIND_MARKET);
    f = '0;
    seen_ctr++;
    off = {1'b0, px} - {1'b0, base_price};
    best = -1;
    if (id == 0 || ts == 0 || qty == 0 || px == 0 ||
        (side != SIDE_BUY && side != SIDE_SELL) ||
        (kind != KIND_LIMIT && kind != KIND_MARKET)) begin
      f.code = OUT_INVALID;
    end else if (!mkt && (px < base_price || off >= LEVELS)) begin
      f.code = OUT_WINDOW;
    end else begin
      // best opposite level
      if (buy) begin
        for (int i = 0; i < LEVELS; i++)
          if (best < 0 && ask_cnt[i] != 0) best = i;
      end else begin
        for (int i = LEVELS-1; i >= 0; i--)
          if (best < 0 && bid_cnt[i] != 0) best = i;
      end
      hit = 0;
      if (best >= 0) begin
        hit = mkt || (buy ? ({32'd0, px} >= {32'd0, base_price} + best)
                          : ({32'd0, px} <= {32'd0, base_price} + best));
      end
      if (hit) begin
        if (buy) begin
          f.matched = ask_ids[best*DEPTH + ask_head[best]];
          ask_head[best] = (ask_head[best] + 1) % DEPTH;
          ask_cnt[best]--;
        end else begin
          f.matched = bid_ids[best*DEPTH + bid_head[best]];
          bid_head[best] = (bid_head[best] + 1) % DEPTH;
          bid_cnt[best]--;
        end
        f.price = base_price + best;
        trade_ctr++;
        f.code = OUT_TRADED;
      end else if (mkt) begin
        f.code = OUT_CANCELLED;
      end else begin
        lvl = int'(off);
        f.code = OUT_RESTED;
        if (buy) begin
          if (bid_cnt[lvl] >= DEPTH) f.code = OUT_FULL;
          else begin
            slot = (bid_head[lvl] + bid_cnt[lvl]) % DEPTH;
            bid_ids[lvl*DEPTH + slot] = id;
            bid_cnt[lvl]++;
          end
        end else begin
          if (ask_cnt[lvl] >= DEPTH) f.code = OUT_FULL;
          else begin
            slot = (ask_head[lvl] + ask_cnt[lvl]) % DEPTH;
            ask_ids[lvl*DEPTH + slot] = id;
            ask_cnt[lvl]++;
          end
        end
      end
    end
    f.seen = seen_ctr;
    f.trades = trade_ctr;
    return f;
  endfunction

  always @(posedge clk) begin
    fill_t want;
    if (rst) begin
      fills_due.delete();
      fail_count <= 0;
      seen_ctr = 0;
      trade_ctr = 0;
      base_price = BASE_RESET;
      for (int i = 0; i < LEVELS; i++) begin
        bid_head[i] = 0; bid_cnt[i] = 0; ask_head[i] = 0; ask_cnt[i] = 0;
      end
    end else begin
      // compare first: a result never leaves in the cycle its order is taken
      if (result_valid && !result_stall) begin
        if (fills_due.size() == 0) begin
          $display("%0t: result with none expected, actual outcome %0d", $time, outcome);
          fail_count <= fail_count + 1;
        end else begin
          want = fills_due[0];
          fills_due.delete(0);
          if (outcome != want.code || matched_resting_id != want.matched ||
              trade_price != want.price || orders_seen != want.seen ||
              trades_done != want.trades) begin
            $display("%0t: mismatch expected %0d/%h/%0d/%0d/%0d actual %0d/%h/%0d/%0d/%0d",
                     $time, want.code, want.matched, want.price, want.seen, want.trades,
                     outcome, matched_resting_id, trade_price, orders_seen, trades_done);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (order_valid && !order_stall)
        fills_due = {fills_due, match_order(order_id, arrival_time, order_side, order_kind,
                                            limit_price, order_quantity)};
      if (cfg_write_en) base_price = cfg_write_data;
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lobm_pkg::*;

  localparam int RANDOM_ORDERS = 1330;
  localparam int IDLE_LIMIT    = 20000;

  logic        clk = 0, rst = 1;
  logic        cfg_write_en = 0;
  logic [31:0] cfg_write_data = 0;
  logic        order_valid = 0, order_stall;
  logic [63:0] order_id = 0, arrival_time = 0, order_quantity = 0;
  logic [1:0]  order_side = 0, order_kind = 0;
  logic [31:0] limit_price = 0;
  logic        result_valid, result_stall = 0;
  logic [2:0]  outcome;
  logic [63:0] matched_resting_id, orders_seen, trades_done;
  logic [31:0] trade_price;
  int          fail_count, pending;
  logic [31:0] base_now = BASE_RESET;
  logic        quiet_tail = 0;
  int          idle_cycles = 0;
  logic [63:0] next_id = 1;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  limit_order_book_matcher_top dut (.*);
  book_checker chk (.*);

  // receiver stall bursts
  always @(negedge clk) begin
    if (!quiet_tail && !result_stall && $urandom_range(0, 9) == 0) begin
      result_stall <= 1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      result_stall <= 0;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((order_valid && !order_stall) || (result_valid && !result_stall) || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_order(logic [63:0] id, logic [63:0] ts, logic [1:0] side,
                            logic [1:0] kind, logic [31:0] px, logic [63:0] qty);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      order_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    order_valid <= 1;
    order_id <= id; arrival_time <= ts; order_side <= side;
    order_kind <= kind; limit_price <= px; order_quantity <= qty;
    @(posedge clk);
    while (order_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // valid order with sequential ids and random arrival time and quantity
  task automatic send_good(logic [1:0] side, logic [1:0] kind, logic [31:0] px);
    send_order(next_id, {$urandom, $urandom} | 64'd1, side, kind, px,
               {$urandom, $urandom} | 64'd1);
    next_id = next_id + 1;
  endtask

  task automatic drain_book();
    order_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (2 * PRICE_LEVELS_DEF + 20) @(negedge clk);
  endtask

  task automatic write_base(logic [31:0] b);
    drain_book();
    cfg_write_en <= 1; cfg_write_data <= b;
    @(negedge clk);
    cfg_write_en <= 0;
    base_now = b;
  endtask

  initial begin
    logic [31:0] px;
    logic [1:0]  sd, kd;
    int          r;
    repeat (2) @(negedge clk);
    rst <= 0;

    // directed: resting, crossing, full level, window edges, invalids
    send_good(SIDE_SELL, KIND_LIMIT, base_now + 10);
    send_good(SIDE_SELL, KIND_LIMIT, base_now + 10);
    send_good(SIDE_BUY, KIND_LIMIT, base_now + 20);
    send_good(SIDE_BUY, KIND_MARKET, 32'hFFFF_FFFF);
    send_good(SIDE_BUY, KIND_MARKET, 1);
    send_good(SIDE_SELL, KIND_MARKET, 1);
    for (int i = 0; i < 9; i++) send_good(SIDE_BUY, KIND_LIMIT, base_now);
    send_good(SIDE_SELL, KIND_LIMIT, base_now + PRICE_LEVELS_DEF - 1);
    send_good(SIDE_SELL, KIND_LIMIT, base_now + PRICE_LEVELS_DEF);
    send_good(SIDE_BUY, KIND_LIMIT, base_now - 1);
    send_order(0, 1, SIDE_BUY, KIND_LIMIT, base_now, 1);
    send_order(64'hFFFF_FFFF_FFFF_FFFF, 0, SIDE_BUY, KIND_LIMIT, base_now, 1);
    send_order(5, 64'hFFFF_FFFF_FFFF_FFFF, SIDE_BUY, KIND_LIMIT, base_now,
               64'hFFFF_FFFF_FFFF_FFFF);
    send_order(6, 1, SIDE_BUY, KIND_LIMIT, base_now, 0);
    send_order(7, 1, 2'd3, KIND_LIMIT, base_now, 1);
    send_order(8, 1, SIDE_SELL, 2'd3, base_now, 1);
    send_order(9, 1, 2'd0, 2'd0, 0, 1);

    // move the base with orders resting, then extremes
    write_base(base_now + 3);
    send_good(SIDE_SELL, KIND_MARKET, 1);
    send_good(SIDE_SELL, KIND_LIMIT, 32'hFFFF_FFFF);
    write_base(32'hFFFF_FF00);
    send_good(SIDE_SELL, KIND_LIMIT, 32'hFFFF_FFFF);
    send_good(SIDE_BUY, KIND_MARKET, 1);
    write_base(0);
    send_good(SIDE_BUY, KIND_LIMIT, 1);
    send_good(SIDE_SELL, KIND_MARKET, 1);
    write_base(BASE_RESET);

    // random: mostly valid orders clustered near mid-window
    for (int n = 0; n < RANDOM_ORDERS; n++) begin
      if (n == 450) write_base($urandom_range(1, 32'hFFFF_FFFF));
      if (n == 700) write_base(BASE_RESET);
      if (n == 900) drain_book();
      if (n == RANDOM_ORDERS - 150) quiet_tail = 1;
      r = $urandom_range(0, 99);
      sd = $urandom_range(0, 1) ? SIDE_BUY : SIDE_SELL;
      kd = ($urandom_range(0, 4) == 0) ? KIND_MARKET : KIND_LIMIT;
      px = base_now + 240 + $urandom_range(0, 32) - (sd == SIDE_BUY ? 12 : 0);
      if (r < 85) send_good(sd, kd, px);
      else if (r < 92) send_good(sd, KIND_LIMIT, $urandom);
      else send_order({$urandom, $urandom} & {64{$urandom_range(0, 1) == 1}},
                      {$urandom, $urandom} & {64{$urandom_range(0, 1) == 1}},
                      2'($urandom), 2'($urandom),
                      $urandom & {32{$urandom_range(0, 3) != 0}},
                      {$urandom, $urandom} & {64{$urandom_range(0, 1) == 1}});
    end

    drain_book();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
rtl/lobm_pkg.sv
rtl/lobm_book.sv
rtl/lobm_seq.sv
rtl/limit_order_book_matcher_top.sv
verif/book_checker.sv
verif/testbench.sv
